FILE: rtl/core/dfs_topo_pkg.sv
`default_nettype none
package dfs_topo_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int CW = VW + 1;

  typedef struct packed {
    logic [5:0] src_vertex;
    logic [5:0] dst_vertex;
    logic       has_edge;
    logic       last_item;
  } dfs_in_t;

  typedef struct packed {
    logic [5:0] vertex_id;
    logic       cycle_found;
    logic       edges_dropped;
    logic       last_result;
  } dfs_out_t;

endpackage
`default_nettype wire

FILE: rtl/core/dfs_topological_sort.sv
`default_nettype none
// Channel   Ports                          Moves
// ------    -----------------------------  --------------------------------
// in        in_valid/in_ready/in_data      one edge request, optional last
// out       out_valid/out_ready/out_data   one vertex of the order, or cycle
// cfg       cfg_we/cfg_wdata               vertex_count register
//
// A stored edge is accepted in S_LOAD, then linked to its source list in S_LINK;
// a marker-only or dropped request is taken in S_LOAD alone. A last request
// starts the walk: vertices are scanned, pushed and popped, and edges followed.
// Each ordered result is read and then held in S_EMWAIT until out_ready. A
// clearing pass over all MAX_VERTICES entries follows every run and the
// synchronous reset; in_ready is low from the last request until that pass ends.
module dfs_topological_sort
  import dfs_topo_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_we,
  input  wire logic [6:0] cfg_wdata,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dfs_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dfs_out_t      out_data
);

  typedef enum logic [3:0] {
    S_CLR, S_LOAD, S_LINK, S_SCAN, S_SCHK, S_PUSH, S_PUSH2, S_TOP, S_POP,
    S_EDGE, S_MCHK, S_CYC, S_EMRD, S_EMSET, S_EMWAIT
  } state_t;

  typedef struct packed {
    logic          valid;
    logic [EW-1:0] first;
    logic [EW-1:0] tail;
  } vtx_t;

  typedef struct packed {
    logic          valid;
    logic [EW-1:0] idx;
  } link_t;

  typedef struct packed {
    logic fin;
    logic onp;
  } mark_t;

  typedef struct packed {
    logic [VW-1:0] v;
    logic          cv;
    logic [EW-1:0] c;
  } stk_t;

  // memories, all with a registered read
  logic [VW-1:0] tgt_mem  [MAX_EDGES];
  link_t         link_mem [MAX_EDGES];
  vtx_t          vtx_mem  [MAX_VERTICES];
  mark_t         mark_mem [MAX_VERTICES];
  stk_t          stk_mem  [MAX_VERTICES];
  logic [VW-1:0] fin_mem  [MAX_VERTICES];

  state_t        state_r;
  logic [6:0]    vcount_r;
  logic [EW:0]   nedge_r;
  logic          drop_r;
  logic [CW-1:0] depth_r, ftot_r, scan_r, idx_r;
  logic [VW-1:0] clr_r, pushv_r, t_r, top_v_r, src_r;
  logic          last_r, top_cv_r;
  logic [EW-1:0] top_c_r;
  logic          out_valid_r;
  dfs_out_t      out_r;

  vtx_t          rd_vtx;
  link_t         rd_link;
  mark_t         rd_mark;
  stk_t          rd_stk;
  logic [VW-1:0] rd_tgt, rd_fin;

  logic          vtx_we;
  logic [VW-1:0] vtx_wa, vtx_ra;
  vtx_t          vtx_wd;
  logic          edge_we, link_we;
  logic [EW-1:0] link_wa;
  link_t         link_wd;
  logic          mark_we;
  logic [VW-1:0] mark_wa, mark_ra;
  mark_t         mark_wd;
  logic          stk_we;
  logic [VW-1:0] stk_wa, stk_ra;
  logic          fin_we;

  logic [CW-1:0] ncnt;
  logic          ld_ok, in_acc;

  always_comb begin
    if (vcount_r == 7'd0) ncnt = CW'(1);
    else if (vcount_r > 7'(MAX_VERTICES)) ncnt = CW'(MAX_VERTICES);
    else ncnt = vcount_r[CW-1:0];
  end
  assign ld_ok = ({1'b0, in_data.src_vertex} < ncnt) &&
                 ({1'b0, in_data.dst_vertex} < ncnt) &&
                 (nedge_r < (EW+1)'(MAX_EDGES));

  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stk_wa = VW'(depth_r - CW'(1));
  assign stk_ra = VW'(depth_r - CW'(2));
  assign stk_we = (state_r == S_PUSH) && (depth_r != '0);
  assign fin_we = (state_r == S_TOP) && !top_cv_r && (ftot_r < CW'(MAX_VERTICES));
  assign mark_ra = (state_r == S_EDGE) ? rd_tgt : scan_r[VW-1:0];

  // select memory write ports by state
  always_comb begin
    vtx_we  = 1'b0;
    vtx_wa  = src_r;
    vtx_wd  = '0;
    vtx_ra  = in_data.src_vertex;
    edge_we = 1'b0;
    link_we = 1'b0;
    link_wa = nedge_r[EW-1:0];
    link_wd = '0;
    mark_we = 1'b0;
    mark_wa = top_v_r;
    mark_wd = '0;
    case (state_r)
      S_CLR: begin
        vtx_we  = 1'b1;
        vtx_wa  = clr_r;
        mark_we = 1'b1;
        mark_wa = clr_r;
      end
      S_LOAD: begin
        if (in_acc && in_data.has_edge && ld_ok) begin
          edge_we = 1'b1;
          link_we = 1'b1;
        end
      end
      S_LINK: begin
        // append to the source list: chain from the old tail or start it
        vtx_we = 1'b1;
        if (rd_vtx.valid) begin
          link_we = 1'b1;
          link_wa = rd_vtx.tail;
          link_wd = '{valid: 1'b1, idx: nedge_r[EW-1:0]};
          vtx_wd  = '{valid: 1'b1, first: rd_vtx.first, tail: nedge_r[EW-1:0]};
        end else begin
          vtx_wd  = '{valid: 1'b1, first: nedge_r[EW-1:0], tail: nedge_r[EW-1:0]};
        end
      end
      S_PUSH: begin
        vtx_ra  = pushv_r;
        mark_we = 1'b1;
        mark_wa = pushv_r;
        mark_wd = '{fin: 1'b0, onp: 1'b1};
      end
      S_TOP: begin
        if (!top_cv_r) begin
          mark_we = 1'b1;
          mark_wd = '{fin: 1'b1, onp: 1'b0};
        end
      end
      default: ;
    endcase
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= 7'd64;
    else if (cfg_we) vcount_r <= cfg_wdata;
  end

  // edge store: target and next-edge link, read at the top cursor
  always_ff @(posedge clk) begin
    if (edge_we) tgt_mem[nedge_r[EW-1:0]] <= in_data.dst_vertex;
    if (link_we) link_mem[link_wa] <= link_wd;
    rd_tgt  <= tgt_mem[top_c_r];
    rd_link <= link_mem[top_c_r];
  end

  // per-vertex list heads and tails
  always_ff @(posedge clk) begin
    if (vtx_we) vtx_mem[vtx_wa] <= vtx_wd;
    rd_vtx <= vtx_mem[vtx_ra];
  end

  // finished and on-path marks
  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    rd_mark <= mark_mem[mark_ra];
  end

  // walk stack below the top entry
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= '{v: top_v_r, cv: top_cv_r, c: top_c_r};
    rd_stk <= stk_mem[stk_ra];
  end

  // finish order
  always_ff @(posedge clk) begin
    if (fin_we) fin_mem[ftot_r[VW-1:0]] <= top_v_r;
    rd_fin <= fin_mem[idx_r[VW-1:0]];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; nedge_r <= '0; drop_r <= 1'b0;
      depth_r <= '0; ftot_r <= '0; scan_r <= '0; idx_r <= '0;
      pushv_r <= '0; t_r <= '0; src_r <= '0; last_r <= 1'b0;
      top_v_r <= '0; top_cv_r <= 1'b0; top_c_r <= '0;
      out_valid_r <= 1'b0; out_r <= '0;
    end else begin
      case (state_r)
        S_CLR: begin
          // clear one vertex entry per cycle
          clr_r <= clr_r + VW'(1);
          if (clr_r == VW'(MAX_VERTICES - 1)) begin
            state_r <= S_LOAD; nedge_r <= '0; drop_r <= 1'b0;
            depth_r <= '0; ftot_r <= '0;
          end
        end
        S_LOAD: if (in_acc) begin
          src_r  <= in_data.src_vertex;
          last_r <= in_data.last_item;
          if (in_data.has_edge && !ld_ok) drop_r <= 1'b1;
          if (in_data.has_edge && ld_ok) state_r <= S_LINK;
          else if (in_data.last_item) begin
            scan_r <= '0; state_r <= S_SCAN;
          end
        end
        S_LINK: begin
          nedge_r <= nedge_r + (EW+1)'(1);
          if (last_r) begin
            scan_r <= '0; state_r <= S_SCAN;
          end else state_r <= S_LOAD;
        end
        S_SCAN: begin
          if (scan_r >= ncnt) begin
            idx_r <= ftot_r - CW'(1); state_r <= S_EMRD;
          end else state_r <= S_SCHK;
        end
        S_SCHK: begin
          scan_r <= scan_r + CW'(1);
          if (!rd_mark.fin) begin
            pushv_r <= scan_r[VW-1:0]; state_r <= S_PUSH;
          end else state_r <= S_SCAN;
        end
        S_PUSH: state_r <= S_PUSH2;  // head read in flight
        S_PUSH2: begin
          top_v_r  <= pushv_r;
          top_cv_r <= rd_vtx.valid;
          top_c_r  <= rd_vtx.first;
          depth_r  <= depth_r + CW'(1);
          state_r  <= S_TOP;
        end
        S_TOP: begin
          if (top_cv_r) state_r <= S_EDGE;
          else begin
            // finish the top vertex and pop
            if (ftot_r < CW'(MAX_VERTICES)) ftot_r <= ftot_r + CW'(1);
            depth_r <= depth_r - CW'(1);
            state_r <= (depth_r == CW'(1)) ? S_SCAN : S_POP;
          end
        end
        S_POP: begin
          top_v_r  <= rd_stk.v;
          top_cv_r <= rd_stk.cv;
          top_c_r  <= rd_stk.c;
          state_r  <= S_TOP;
        end
        S_EDGE: begin
          // advance the cursor, skip targets beyond the count
          top_cv_r <= rd_link.valid;
          top_c_r  <= rd_link.idx;
          t_r      <= rd_tgt;
          state_r  <= ({1'b0, rd_tgt} >= ncnt) ? S_TOP : S_MCHK;
        end
        S_MCHK: begin
          if (rd_mark.onp) begin
            out_r <= '{vertex_id: '0, cycle_found: 1'b1,
                       edges_dropped: drop_r, last_result: 1'b1};
            out_valid_r <= 1'b1; state_r <= S_CYC;
          end else if (!rd_mark.fin) begin
            pushv_r <= t_r; state_r <= S_PUSH;
          end else state_r <= S_TOP;
        end
        S_CYC: if (out_ready) begin
          out_valid_r <= 1'b0; state_r <= S_CLR;
        end
        S_EMRD: state_r <= S_EMSET;  // finish-order read in flight
        S_EMSET: begin
          out_r <= '{vertex_id: rd_fin, cycle_found: 1'b0,
                     edges_dropped: drop_r, last_result: (idx_r == '0)};
          out_valid_r <= 1'b1; state_r <= S_EMWAIT;
        end
        S_EMWAIT: if (out_ready) begin
          out_valid_r <= 1'b0;
          if (idx_r == '0) state_r <= S_CLR;
          else begin
            idx_r <= idx_r - CW'(1); state_r <= S_EMRD;
          end
        end
        default: state_r <= S_CLR;
      endcase
    end
  end

endmodule
`default_nettype wire
